[hw/rtl/u16u8_pkg.sv]
package u16u8_pkg;

   localparam int SeqBytes = 6;

   localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
   localparam logic [15:0] SURR_HIGH_HI = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [20:0] MAX_ONE      = 21'h7F;
   localparam logic [20:0] MAX_TWO      = 21'h7FF;
   localparam logic [20:0] MAX_THREE    = 21'hFFFF;
   localparam logic [7:0]  LEAD_TWO     = 8'hC0;
   localparam logic [7:0]  LEAD_THREE   = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
   localparam logic [7:0]  CONT_MARK    = 8'h80;

   // One encoded code point, first byte in element 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } enc_type;

   // Work for the back end: all bytes caused by one input unit.
   typedef struct packed {
      logic [SeqBytes-1:0][7:0] bytes;
      logic [2:0]               len;
      logic                     string_end;
   } seq_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic enc_type encode_point(input logic [20:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp <= MAX_ONE) begin
         e.bytes[0] = {1'b0, cp[6:0]};
         e.len      = 3'd1;
      end else if (cp <= MAX_TWO) begin
         e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
         e.len      = 3'd2;
      end else if (cp <= MAX_THREE) begin
         e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
         e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
         e.len      = 3'd3;
      end else begin
         e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
         e.len      = 3'd4;
      end
      return e;
   endfunction

endpackage

[hw/rtl/u16u8_front.sv]
module u16u8_front import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_string_last,
   input  qstat_type   q_stat,
   output logic        push,
   output seq_type     push_seq,
   output logic        pend_valid
);

   logic       pend_ff, pend_in;
   logic [9:0] held_ff, held_in;
   logic       accept, is_high, is_low, keep;
   enc_type    held_enc, unit_enc, supp_enc;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign is_high   = (req_code_unit >= SURR_HIGH_LO) && (req_code_unit <= SURR_HIGH_HI);
   assign is_low    = (req_code_unit >= SURR_LOW_LO) && (req_code_unit <= SURR_LOW_HI);
   assign keep      = is_high && !req_string_last;

   assign held_enc = encode_point({5'b00000, SURR_HIGH_LO | {6'b000000, held_ff}});
   assign unit_enc = encode_point({5'b00000, req_code_unit});
   assign supp_enc = encode_point({1'b0, held_ff, req_code_unit[9:0]} + SUPP_BASE);

   always_comb begin
      push_seq            = '0;
      push_seq.string_end = req_string_last;
      if (pend_ff) begin
         if (is_low) begin
            push_seq.bytes[3:0] = supp_enc.bytes;
            push_seq.len        = supp_enc.len;
         end else begin
            // The held surrogate goes out alone, then the new unit unless it is held.
            push_seq.bytes[2:0] = held_enc.bytes[2:0];
            if (keep) begin
               push_seq.len = 3'd3;
            end else begin
               push_seq.bytes[5:3] = unit_enc.bytes[2:0];
               push_seq.len        = 3'd3 + unit_enc.len;
            end
         end
      end else if (!keep) begin
         push_seq.bytes[3:0] = unit_enc.bytes;
         push_seq.len        = unit_enc.len;
      end
   end

   assign push       = accept && (push_seq.len != 3'd0);
   assign pend_in    = accept ? keep : pend_ff;
   assign held_in    = (accept && keep) ? req_code_unit[9:0] : held_ff;
   assign pend_valid = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

[hw/rtl/u16u8_queue.sv]
module u16u8_queue import u16u8_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  seq_type   push_seq,
   input  logic      pop,
   output seq_type   head,
   output qstat_type q_stat
);

   seq_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign head         = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_seq;
      end
   end

endmodule

[hw/rtl/u16u8_back.sv]
module u16u8_back import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  seq_type     head,
   input  qstat_type   q_stat,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff, string_end_ff;
   logic [2:0] idx_ff, idx_in;
   logic       load, last_b;

   // While the queue is not empty, a new byte enters the output register whenever it is empty or being transferred.
   assign load   = !q_stat.empty && (!valid_ff || rsp_ready);
   assign last_b = (idx_ff == (head.len - 3'd1));
   assign pop    = load && last_b;

   assign valid_in = load || (valid_ff && !rsp_ready);
   assign idx_in   = load ? (last_b ? 3'd0 : idx_ff + 3'd1) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= head.bytes[idx_ff];
         run_last_ff   <= last_b;
         string_end_ff <= last_b && head.string_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = string_end_ff;

endmodule

[hw/rtl/utf16_to_utf8_converter.sv]
// A transferred unit is queued first; its bytes then leave via the output register.
// Throughput: one UTF-8 byte per cycle at the output register while bytes wait and
// rsp_ready is held high; a unit yields 0 to 6 bytes (1 to 3 for typical text).
// A two-entry queue between front and back lets a new unit be taken while bytes drain.
// Reset (synchronous, active high) clears the held surrogate, the queue and the output.
module utf16_to_utf8_converter import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_string_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);

   qstat_type q_stat;
   seq_type   push_seq, head;
   logic      push, pop, pend_valid;

   u16u8_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_string_last (req_string_last),
      .q_stat          (q_stat),
      .push            (push),
      .push_seq        (push_seq),
      .pend_valid      (pend_valid)
   );

   u16u8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_seq (push_seq),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   u16u8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_stat         (q_stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end flagged on a byte that does not close its run");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty at once");

   a_nothing_held_after_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_string_last |=> !pend_valid)
      else $error("surrogate still held after the last unit of a string");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("transfer into a full queue");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import u16u8_pkg::*;

   localparam int unsigned RandomUnits = 270;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned MaxReports  = 10;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_phase_type;

   typedef struct packed {
      logic [15:0]    unit;
      logic           last;
      idle_phase_type phase;
   } code_unit_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
   } utf8_byte_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit   = '0;
   logic        req_string_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_end;

   code_unit_type  pending_units[$];
   utf8_byte_type  expected_bytes[$];
   code_unit_type  next_unit;
   utf8_byte_type  want_byte;
   idle_phase_type idle_phase = IDLE_NONE;

   // Predictor state: the high surrogate waiting for its partner.
   logic        held_valid = 1'b0;
   logic [9:0]  held_bits  = '0;

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   utf16_to_utf8_converter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_string_last (req_string_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_end  (rsp_string_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned idle_pct(idle_phase_type ph, logic sender);
      case (ph)
         IDLE_SEND: return sender ? 58 : 0;
         IDLE_RECV: return sender ? 0 : 58;
         IDLE_BOTH: return 11;
         default:   return 0;
      endcase
   endfunction

   task automatic add_unit(input logic [15:0] unit, input logic last,
                           input idle_phase_type ph);
      code_unit_type item;
      item.unit  = unit;
      item.last  = last;
      item.phase = ph;
      pending_units.push_back(item);
   endtask

   // Works out the UTF-8 bytes that one transferred code unit releases.
   task automatic predict_unit(input logic [15:0] unit, input logic last);
      logic [20:0] points[$];
      logic        is_high;
      logic        is_low;
      logic        paired;
      logic [7:0]  lead;
      logic [7:0]  lead_mask;
      logic [7:0]  data;
      int unsigned len;
      int unsigned n_new;
      int unsigned k;
      is_high = (unit >= SURR_HIGH_LO) && (unit <= SURR_HIGH_HI);
      is_low  = (unit >= SURR_LOW_LO) && (unit <= SURR_LOW_HI);
      paired  = held_valid && is_low;
      n_new   = 0;
      if (held_valid) begin
         points.push_back(paired ? SUPP_BASE + {1'b0, held_bits, unit[9:0]}
                                 : {5'd0, SURR_HIGH_LO[15:10], held_bits});
      end
      held_valid = 1'b0;
      if (!paired) begin
         if (is_high && !last) begin
            held_valid = 1'b1;
            held_bits  = unit[9:0];
         end else begin
            points.push_back({5'd0, unit});
         end
      end
      foreach (points[i]) begin
         if (points[i] <= MAX_ONE) len = 1;
         else if (points[i] <= MAX_TWO) len = 2;
         else if (points[i] <= MAX_THREE) len = 3;
         else len = 4;
         case (len)
            1: {lead, lead_mask} = {8'h00, 8'h7F};
            2: {lead, lead_mask} = {LEAD_TWO, 8'h1F};
            3: {lead, lead_mask} = {LEAD_THREE, 8'h0F};
            default: {lead, lead_mask} = {LEAD_FOUR, 8'h07};
         endcase
         for (k = 0; k < len; k++) begin
            data = 8'(points[i] >> (6 * (len - 1 - k)));
            data = (k == 0) ? (lead | (data & lead_mask)) : (CONT_MARK | (data & 8'h3F));
            expected_bytes.push_back('{data, 1'b0, 1'b0});
            n_new++;
         end
      end
      if (n_new > 0) begin
         expected_bytes[expected_bytes.size() - 1].run_last   = 1'b1;
         expected_bytes[expected_bytes.size() - 1].string_end = last;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_unit(req_code_unit, req_string_last);
         end
         // The port is free once the current unit has been transferred.
         if (!req_valid || req_ready) begin
            if (pending_units.size() != 0 &&
                $urandom_range(99) >= idle_pct(pending_units[0].phase, 1'b1)) begin
               next_unit = pending_units.pop_front();
               req_valid       <= 1'b1;
               req_code_unit   <= next_unit.unit;
               req_string_last <= next_unit.last;
               idle_phase      <= next_unit.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct(idle_phase, 1'b0));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
               $display("unexpected byte %h run_last %b string_end %b",
                        rsp_out_byte, rsp_run_last, rsp_string_end);
            end
         end else begin
            want_byte = expected_bytes.pop_front();
            if (rsp_out_byte !== want_byte.data || rsp_run_last !== want_byte.run_last ||
                rsp_string_end !== want_byte.string_end) begin
               fail_count++;
               if (fail_count <= MaxReports) begin
                  $display("mismatch: expected byte %h run_last %b string_end %b, got %h %b %b",
                           want_byte.data, want_byte.run_last, want_byte.string_end,
                           rsp_out_byte, rsp_run_last, rsp_string_end);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int unsigned    n_random;
      int unsigned    str_len;
      int unsigned    pick;
      logic           final_pos;
      logic           broken;
      idle_phase_type ph;

      // Directed part: byte-length boundaries, surrogate pairing and release.
      add_unit(16'h0000, 1'b1, IDLE_NONE);
      add_unit(16'h007F, 1'b0, IDLE_NONE);
      add_unit(16'h0080, 1'b0, IDLE_NONE);
      add_unit(16'h07FF, 1'b0, IDLE_NONE);
      add_unit(16'h0800, 1'b0, IDLE_NONE);
      add_unit(16'hFFFF, 1'b1, IDLE_NONE);
      add_unit(SURR_HIGH_LO, 1'b0, IDLE_NONE);
      add_unit(SURR_LOW_LO, 1'b0, IDLE_NONE);
      add_unit(SURR_HIGH_HI, 1'b0, IDLE_NONE);
      add_unit(SURR_LOW_HI, 1'b1, IDLE_NONE);
      add_unit(16'hD834, 1'b0, IDLE_NONE);
      add_unit(16'h0041, 1'b0, IDLE_NONE);
      add_unit(SURR_HIGH_LO, 1'b0, IDLE_NONE);
      add_unit(SURR_HIGH_HI, 1'b0, IDLE_NONE);
      add_unit(SURR_LOW_LO, 1'b1, IDLE_NONE);
      add_unit(SURR_HIGH_HI, 1'b1, IDLE_NONE);
      add_unit(SURR_LOW_HI, 1'b0, IDLE_NONE);
      add_unit(16'hD912, 1'b0, IDLE_NONE);
      add_unit(16'hE000, 1'b1, IDLE_NONE);
      add_unit(16'hDABC, 1'b0, IDLE_NONE);
      add_unit(16'hD801, 1'b1, IDLE_NONE);
      add_unit(SURR_LOW_LO, 1'b1, IDLE_NONE);

      // Random strings, mostly well formed, with the odd broken one.
      n_random = 0;
      while (n_random < RandomUnits) begin
         ph      = idle_phase_type'((n_random * 4) / RandomUnits);
         str_len = $urandom_range(1, 10);
         broken  = ($urandom_range(9) == 0);
         for (int pos = 0; pos < str_len; pos++) begin
            final_pos = (pos == str_len - 1);
            pick      = $urandom_range(99);
            if (broken) begin
               add_unit(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)), ph);
            end else if (pick < 25) begin
               add_unit(16'($urandom_range(16'h007F)), final_pos, ph);
            end else if (pick < 40) begin
               add_unit(16'($urandom_range(16'h0080, 16'h07FF)), final_pos, ph);
            end else if (pick < 55) begin
               if ($urandom_range(1))
                  add_unit(16'($urandom_range(16'h0800, 16'hD7FF)), final_pos, ph);
               else
                  add_unit(16'($urandom_range(16'hE000, 16'hFFFF)), final_pos, ph);
            end else if (pick < 80) begin
               add_unit(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 1'b0, ph);
               add_unit(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), final_pos, ph);
               n_random++;
            end else if (pick < 87) begin
               add_unit(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), final_pos, ph);
            end else if (pick < 94) begin
               add_unit(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), final_pos, ph);
            end else begin
               add_unit(16'($urandom_range(16'hFFFF)), final_pos, ph);
            end
            n_random++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_units.size() != 0 || req_valid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
